@@ hw/rtl/hcd_pkg.sv @@
`timescale 1ns / 1ps
// hcd_pkg: shared widths, codes, state type and queued command type of the
// huffman code table decoder; depends on nothing

package hcd_pkg;

    // fixed field widths
    localparam int OP_W        = 2;
    localparam int SYM_W       = 7;
    localparam int CODE_LEN_W  = 6;
    localparam int LEN_W       = 7;   // saturated code length, up to 63
    localparam int CODE_W      = 32;
    localparam int BYTE_BITS   = 8;
    localparam int CNT_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int QDEPTH      = 2;

    // defaults for the top level parameters
    localparam int ALPHABET_SIZE_DEF = 128;
    localparam int NODE_DEPTH_DEF    = 256;
    localparam int MAX_CODE_LEN_DEF  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DECODE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_SYMBOL     = 2'd0,
        STS_NO_CHILD   = 2'd1,
        STS_TABLE_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_LOAD,
        BS_DEC,
        BS_CHK,
        BS_END
    } t_bstate;

    // classified item as it travels from the front to the back
    typedef struct packed {
        t_op                  kind;
        logic [SYM_W-1:0]     sym;
        logic [LEN_W-1:0]     len;
        logic [CODE_W-1:0]    code;
        logic [BYTE_BITS-1:0] dbyte;
        logic [CNT_W-1:0]     cnt;
    } t_cmd;

endpackage

@@ hw/rtl/huffman_code_table_decoder_unit.sv @@
`timescale 1ns / 1ps
// huffman_code_table_decoder_unit: top level of the huffman code table decoder
// uses hcd_pkg, hcd_front, hcd_back (which holds the hcd_ram node memory)

// Huffman decoder over a code tree built from loaded code table entries. An
// input item is a clear (empties the tree, no result), a load (one symbol with
// its code, MSB first; allocates missing nodes, no result unless the node table
// is full, then one result with status table full) or a data byte (walks the
// tree on the leading valid bits, MSB first, giving one result per leaf reached
// and one with status missing child per bit that steps into an absent child).
// The walk position is kept across data bytes. The last result an item causes
// has last set; an item may cause no result at all. Items pass through a
// two-entry queue to the tree engine, so input is taken while the engine works.
// The engine takes one item at a time; the node memory's registered read must
// return each child before its leaf test and the next step, and a stalled result
// output holds the engine. The root node lives in flops and reset clears it, so
// the tree is empty right after reset with no sweep of the node memory.

module huffman_code_table_decoder_unit #(
    parameter int ALPHABET_SIZE = hcd_pkg::ALPHABET_SIZE_DEF,
    parameter int NODE_DEPTH    = hcd_pkg::NODE_DEPTH_DEF,
    parameter int MAX_CODE_LEN  = hcd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hcd_pkg::OP_W-1:0]        i_operation,
    input  logic [hcd_pkg::SYM_W-1:0]       i_symbol_in,
    input  logic [hcd_pkg::CODE_LEN_W-1:0]  i_code_length,
    input  logic [hcd_pkg::CODE_W-1:0]      i_code_bits,
    input  logic [hcd_pkg::BYTE_BITS-1:0]   i_data_byte,
    input  logic [hcd_pkg::CNT_W-1:0]       i_valid_bits,
    // result item channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hcd_pkg::SYM_W-1:0]       o_symbol_out,
    output logic [hcd_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_last
);
    import hcd_pkg::*;

    // queue between front and back
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    // front: classify, saturate length and bit count, reduce symbol, queue
    hcd_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_symbol_in   (i_symbol_in),
        .i_code_length (i_code_length),
        .i_code_bits   (i_code_bits),
        .i_data_byte   (i_data_byte),
        .i_valid_bits  (i_valid_bits),
        .o_q_valid     (q_valid),
        .i_q_ready     (q_ready),
        .o_q_cmd       (q_cmd)
    );

    // back: tree walks over the node memory, result register on the output
    hcd_back #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_cmd      (q_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_symbol_out (o_symbol_out),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

@@ hw/rtl/hcd_ram.sv @@
`timescale 1ns / 1ps
// hcd_ram: generic single write port, single read port ram with registered read
// no dependencies

module hcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/hcd_front.sv @@
`timescale 1ns / 1ps
// hcd_front: accepts input items, classifies and saturates their fields and
// queues them for the back end; uses hcd_pkg

module hcd_front #(
    parameter int ALPHABET_SIZE = hcd_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_CODE_LEN  = hcd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hcd_pkg::OP_W-1:0]        i_operation,
    input  logic [hcd_pkg::SYM_W-1:0]       i_symbol_in,
    input  logic [hcd_pkg::CODE_LEN_W-1:0]  i_code_length,
    input  logic [hcd_pkg::CODE_W-1:0]      i_code_bits,
    input  logic [hcd_pkg::BYTE_BITS-1:0]   i_data_byte,
    input  logic [hcd_pkg::CNT_W-1:0]       i_valid_bits,
    output logic                            o_q_valid,
    input  logic                            i_q_ready,
    output hcd_pkg::t_cmd                   o_q_cmd
);
    import hcd_pkg::*;

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [SYM_W-1:0] mod_tab [2**SYM_W];
    t_cmd             cmd;
    logic             is_cmd;
    logic             push;
    logic             pop;

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    // symbol modulo alphabet size as a constant table
    for (genvar g = 0; g < 2**SYM_W; g++) begin : g_mod
        assign mod_tab[g] = SYM_W'(g % ALPHABET_SIZE);
    end

    always_comb begin
        cmd.kind  = t_op'(i_operation);
        cmd.sym   = mod_tab[i_symbol_in];
        cmd.len   = (LEN_W'(i_code_length) > LEN_W'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : LEN_W'(i_code_length);
        cmd.code  = i_code_bits;
        cmd.dbyte = i_data_byte;
        cmd.cnt   = (i_valid_bits > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : i_valid_bits;
        case (t_op'(i_operation))
            OP_CLEAR, OP_LOAD, OP_DECODE: is_cmd = 1'b1;
            default:                      is_cmd = 1'b0;   // unused code, dropped
        endcase
    end

    assign o_in_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_cmd    = r_q[r_rptr];
    assign push       = i_in_valid && o_in_ready && is_cmd;
    assign pop        = o_q_valid && i_q_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_wptr + 1'b1);
        end
        if (pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_rptr + 1'b1);
        end
        if (push && !pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd;
        end
    end

endmodule

@@ hw/rtl/hcd_back.sv @@
`timescale 1ns / 1ps
// hcd_back: tree engine that carries out clear, load and decode commands over
// the node ram and drives the result register; uses hcd_pkg and hcd_ram

module hcd_back #(
    parameter int NODE_DEPTH = hcd_pkg::NODE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  hcd_pkg::t_cmd                 i_q_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hcd_pkg::SYM_W-1:0]     o_symbol_out,
    output logic [hcd_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);
    import hcd_pkg::*;

    localparam int KID_W  = $clog2(NODE_DEPTH);
    localparam int NF_W   = $clog2(NODE_DEPTH + 1);
    localparam int NODE_W = 2 * KID_W + SYM_W;
    localparam int K0_LSB = SYM_W;
    localparam int K1_LSB = SYM_W + KID_W;

    t_bstate              r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [BYTE_BITS-1:0] r_byte, n_byte;
    logic [KID_W-1:0]     r_cur, n_cur;
    logic                 r_fresh, n_fresh;
    logic [KID_W-1:0]     r_walk, n_walk;
    logic [NODE_W-1:0]    r_root, n_root;
    logic [NF_W-1:0]      r_next_free, n_next_free;
    logic                 r_pend_valid, n_pend_valid;
    logic [SYM_W-1:0]     r_pend_sym, n_pend_sym;
    t_status              r_pend_status, n_pend_status;
    logic                 r_out_valid, n_out_valid;
    logic [SYM_W-1:0]     r_out_sym, n_out_sym;
    t_status              r_out_status, n_out_status;
    logic                 r_out_last, n_out_last;

    logic                 ram_we, ram_re;
    logic [KID_W-1:0]     ram_waddr, ram_raddr;
    logic [NODE_W-1:0]    ram_wdata, ram_rdata;

    logic [NODE_W-1:0]    cur_node;
    logic [KID_W-1:0]     cur_kid0, cur_kid1, kid;
    logic                 leaf;
    logic [LEN_W-1:0]     pos;
    logic                 code_bit, step_bit;
    logic                 table_full;
    logic                 out_free, can_emit;
    logic                 wr;
    logic [NODE_W-1:0]    wnode;
    logic                 new_res;
    logic [SYM_W-1:0]     new_sym;
    t_status              new_sts;
    logic                 push, push_last;

    hcd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // root in flops, a freshly allocated node is known empty, others from ram
    always_comb begin
        if (r_cur == '0) begin
            cur_node = r_root;
        end else if (r_fresh) begin
            cur_node = '0;
        end else begin
            cur_node = ram_rdata;
        end
    end

    assign cur_kid0   = cur_node[K0_LSB +: KID_W];
    assign cur_kid1   = cur_node[K1_LSB +: KID_W];
    assign leaf       = (cur_kid0 == '0) && (cur_kid1 == '0);
    assign pos        = LEN_W'(r_rem - 1'b1);
    assign code_bit   = (pos < LEN_W'(CODE_W)) ? r_cmd.code[pos[4:0]] : 1'b0;
    assign step_bit   = (r_state == BS_LOAD) ? code_bit : r_byte[BYTE_BITS-1];
    assign kid        = step_bit ? cur_kid1 : cur_kid0;
    assign table_full = (r_next_free >= NF_W'(NODE_DEPTH));
    assign out_free   = !r_out_valid || i_out_ready;
    assign can_emit   = !r_pend_valid || out_free;
    assign o_q_ready  = (r_state == BS_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        OP_LOAD:   n_state = BS_LOAD;
                        OP_DECODE: n_state = BS_DEC;
                        default:   n_state = BS_IDLE;
                    endcase
                end
            end
            BS_LOAD: begin
                if (r_rem == '0) begin
                    n_state = BS_IDLE;
                end else if (kid == '0 && table_full && can_emit) begin
                    n_state = BS_END;
                end
            end
            BS_DEC: begin
                if (r_rem == '0) begin
                    n_state = BS_END;
                end else if (kid != '0) begin
                    n_state = BS_CHK;
                end
            end
            BS_CHK: begin
                if (!leaf || can_emit) begin
                    n_state = BS_DEC;
                end
            end
            BS_END: begin
                if (!r_pend_valid || out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd         = r_cmd;
        n_rem         = r_rem;
        n_byte        = r_byte;
        n_cur         = r_cur;
        n_fresh       = r_fresh;
        n_walk        = r_walk;
        n_root        = r_root;
        n_next_free   = r_next_free;
        n_pend_valid  = r_pend_valid;
        n_pend_sym    = r_pend_sym;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid;
        n_out_sym     = r_out_sym;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = r_cur;
        ram_raddr     = kid;
        ram_wdata     = cur_node;
        wr            = 1'b0;
        wnode         = cur_node;
        new_res       = 1'b0;
        new_sym       = '0;
        new_sts       = STS_SYMBOL;
        push          = 1'b0;
        push_last     = 1'b0;

        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    n_cmd = i_q_cmd;
                    case (i_q_cmd.kind)
                        OP_CLEAR: begin
                            n_root      = '0;
                            n_next_free = NF_W'(1);
                            n_walk      = '0;
                        end
                        OP_LOAD: begin
                            n_cur   = '0;
                            n_fresh = 1'b0;
                            n_rem   = i_q_cmd.len;
                        end
                        OP_DECODE: begin
                            n_cur     = r_walk;
                            n_fresh   = 1'b0;
                            n_rem     = LEN_W'(i_q_cmd.cnt);
                            n_byte    = i_q_cmd.dbyte;
                            ram_re    = (r_walk != '0);
                            ram_raddr = r_walk;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_LOAD: begin
                if (r_rem == '0) begin
                    // end of code: store the symbol at this node
                    wr    = 1'b1;
                    wnode = {cur_kid1, cur_kid0, r_cmd.sym};
                end else if (kid == '0) begin
                    if (table_full) begin
                        // keep a fresh node's empty contents in the ram
                        wr = 1'b1;
                        if (can_emit) begin
                            new_res = 1'b1;
                            new_sts = STS_TABLE_FULL;
                        end
                    end else begin
                        wr = 1'b1;
                        if (step_bit) begin
                            wnode[K1_LSB +: KID_W] = r_next_free[KID_W-1:0];
                        end else begin
                            wnode[K0_LSB +: KID_W] = r_next_free[KID_W-1:0];
                        end
                        n_cur       = r_next_free[KID_W-1:0];
                        n_fresh     = 1'b1;
                        n_next_free = r_next_free + NF_W'(1);
                        n_rem       = LEN_W'(r_rem - 1'b1);
                    end
                end else begin
                    n_cur   = kid;
                    n_fresh = 1'b0;
                    ram_re  = 1'b1;
                    n_rem   = LEN_W'(r_rem - 1'b1);
                end
            end
            BS_DEC: begin
                if (r_rem != '0) begin
                    if (kid == '0) begin
                        if (can_emit) begin
                            new_res = 1'b1;
                            new_sts = STS_NO_CHILD;
                            n_cur   = '0;
                            n_walk  = '0;
                            n_rem   = LEN_W'(r_rem - 1'b1);
                            n_byte  = {r_byte[BYTE_BITS-2:0], 1'b0};
                        end
                    end else begin
                        n_cur   = kid;
                        n_walk  = kid;
                        n_fresh = 1'b0;
                        ram_re  = 1'b1;
                        n_rem   = LEN_W'(r_rem - 1'b1);
                        n_byte  = {r_byte[BYTE_BITS-2:0], 1'b0};
                    end
                end
            end
            BS_CHK: begin
                if (leaf && can_emit) begin
                    new_res = 1'b1;
                    new_sym = cur_node[SYM_W-1:0];
                    new_sts = STS_SYMBOL;
                    n_cur   = '0;
                    n_walk  = '0;
                end
            end
            BS_END: begin
                if (r_pend_valid && out_free) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (wr) begin
            if (r_cur == '0) begin
                n_root = wnode;
            end else begin
                ram_we    = 1'b1;
                ram_wdata = wnode;
            end
        end

        // a result waits one step so the final one can carry last
        if (new_res) begin
            if (r_pend_valid) begin
                push = 1'b1;
            end
            n_pend_valid  = 1'b1;
            n_pend_sym    = new_sym;
            n_pend_status = new_sts;
        end

        if (push) begin
            n_out_valid  = 1'b1;
            n_out_sym    = r_pend_sym;
            n_out_status = r_pend_status;
            n_out_last   = push_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_cur        <= '0;
            r_fresh      <= 1'b0;
            r_walk       <= '0;
            r_root       <= '0;
            r_next_free  <= NF_W'(1);
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_fresh      <= n_fresh;
            r_walk       <= n_walk;
            r_root       <= n_root;
            r_next_free  <= n_next_free;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_rem         <= n_rem;
        r_byte        <= n_byte;
        r_pend_sym    <= n_pend_sym;
        r_pend_status <= n_pend_status;
        r_out_sym     <= n_out_sym;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_symbol_out = r_out_sym;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

`ifndef SYNTH
    a_next_free_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != '0) && (r_next_free <= NF_W'(NODE_DEPTH)))
        else $error("next free node out of range");
    a_idle_no_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_IDLE) |-> !r_pend_valid)
        else $error("result left pending across items");
    a_ram_one_access : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("node ram read and written in one cycle");
    a_fresh_not_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> (r_cur != '0))
        else $error("root marked as freshly allocated");
`endif

endmodule
